// File: rtl/wtc_pkg.sv
// wtc_pkg: shared types and constants of the whitespace token chunker.
// Payload structs, register indexes, separator codes and parameter defaults.
// No dependencies.
package wtc_pkg;

    // Parameter defaults
    localparam int DEF_WINDOW_DEPTH  = 256;
    localparam int DEF_POSITION_BITS = 31;

    // Output field width, fixed by the interface
    localparam int FIELD_W = 31;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_TOKENS = 1'd1;

    localparam logic [8:0] MAX_TOKENS_RESET     = 9'd128;
    localparam logic [7:0] OVERLAP_TOKENS_RESET = 8'd0;

    // Token separators
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } wtc_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] chunk_id;
        logic [FIELD_W-1:0] span_start;
        logic [FIELD_W-1:0] span_end;
        logic               final_chunk;
    } wtc_out_t;

    // Pending result from the scanner; span_start follows from the ring read
    typedef struct packed {
        logic               emit;
        logic [FIELD_W-1:0] chunk_id;
        logic [FIELD_W-1:0] span_end;
        logic               final_chunk;
    } wtc_pend_t;

endpackage

// File: rtl/wtc_ring.sv
// wtc_ring: token start ring, one write and one read port, registered read.
// A read of the entry written in the same cycle returns the new data.
// Depends on nothing.
module wtc_ring #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first forwarding on an address match
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/wtc_scan.sv
// wtc_scan: per-byte token tracking, window counting and ring addressing.
// Holds the scalar text state; drives the ring ports and the pending result.
// Depends on wtc_pkg.
module wtc_scan
    import wtc_pkg::*;
#(
    parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wtc_in_t                         text,
    input  logic                            accept,
    input  logic [8:0]                      max_tokens,
    input  logic [7:0]                      overlap_tokens,
    output logic                            ring_we,
    output logic [$clog2(WINDOW_DEPTH)-1:0] ring_waddr,
    output logic [POSITION_BITS-1:0]        ring_wdata,
    output logic                            ring_re,
    output logic [$clog2(WINDOW_DEPTH)-1:0] ring_raddr,
    output wtc_pend_t                       pend
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int MW    = (CNT_W > 9) ? CNT_W : 9;
    localparam int SUM_W = CNT_W + 1;

    localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
    localparam logic [FIELD_W-1:0]       CHUNK_MAX = {FIELD_W{1'b1}};
    localparam logic [IDX_W-1:0]         IDX_LAST  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]         CNT_TOP   = CNT_W'(WINDOW_DEPTH);
    localparam logic [MW-1:0]            M_TOP     = MW'(WINDOW_DEPTH);
    localparam logic [SUM_W-1:0]         SUM_DEPTH = SUM_W'(WINDOW_DEPTH);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     inside_reg, inside_next;
    logic [POSITION_BITS-1:0] open_start_reg, open_start_next;
    logic [IDX_W-1:0]         wi_reg, wi_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     unemit_reg, unemit_next;
    logic [POSITION_BITS-1:0] prev_end_reg, prev_end_next;
    logic [FIELD_W-1:0]       chunk_cnt_reg, chunk_cnt_next;

    logic                     ws;
    logic                     ends;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] tok_start;
    logic [POSITION_BITS-1:0] end_at;
    logic [IDX_W-1:0]         wi_inc;
    logic [IDX_W-1:0]         wi_new;
    logic [CNT_W-1:0]         count_inc;
    logic [CNT_W-1:0]         count_after;
    logic [MW-1:0]            m_wide;
    logic [MW-1:0]            ov_wide;
    logic [CNT_W-1:0]         m_eff;
    logic [CNT_W-1:0]         ov_eff;
    logic                     full;
    logic                     unemit_after;
    logic                     partial;
    logic                     emit;
    logic [CNT_W-1:0]         back_n;
    logic [SUM_W-1:0]         back_sum;
    logic [SUM_W-1:0]         back_idx;
    logic [POSITION_BITS-1:0] span_end_pos;

    always_comb
    begin
        ws = (text.text_byte == CH_SPACE) || (text.text_byte == CH_TAB) ||
             (text.text_byte == CH_LF) || (text.text_byte == CH_CR);

        pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        tok_start = inside_reg ? open_start_reg : pos_reg;
        ends      = ws ? inside_reg : text.last_byte;
        end_at    = ws ? pos_reg : pos_inc;

        wi_inc = (wi_reg == IDX_LAST) ? '0 : wi_reg + 1'b1;
        wi_new = ends ? wi_inc : wi_reg;

        count_inc   = (count_reg >= CNT_TOP) ? count_reg : count_reg + 1'b1;
        count_after = ends ? count_inc : count_reg;

        // window size clamped to 1..depth, overlap to size minus one
        m_wide = MW'(max_tokens);
        if (m_wide == '0)
        begin
            m_wide = MW'(1);
        end
        if (m_wide > M_TOP)
        begin
            m_wide = M_TOP;
        end
        m_eff   = CNT_W'(m_wide);
        ov_wide = MW'(overlap_tokens);
        if (ov_wide > (m_wide - 1'b1))
        begin
            ov_wide = m_wide - 1'b1;
        end
        ov_eff = CNT_W'(ov_wide);

        full         = ends && (count_inc >= m_eff);
        unemit_after = ends ? !full : unemit_reg;
        partial      = text.last_byte && !full && unemit_after && (count_after != '0);
        emit         = full || partial;

        // ring slot n tokens back from the new write index
        back_n   = full ? m_eff : count_after;
        back_sum = SUM_W'(wi_new) + SUM_DEPTH - SUM_W'(back_n);
        back_idx = (back_sum >= SUM_DEPTH) ? back_sum - SUM_DEPTH : back_sum;

        span_end_pos = ends ? end_at : prev_end_reg;
    end

    assign ring_we    = accept && ends;
    assign ring_waddr = wi_reg;
    assign ring_wdata = tok_start;
    assign ring_re    = accept && emit;
    assign ring_raddr = IDX_W'(back_idx);

    always_comb
    begin
        pend.emit        = emit;
        pend.chunk_id    = chunk_cnt_reg;
        pend.span_end    = FIELD_W'(span_end_pos);
        pend.final_chunk = text.last_byte;
    end

    always_comb
    begin
        pos_next        = pos_reg;
        inside_next     = inside_reg;
        open_start_next = open_start_reg;
        wi_next         = wi_reg;
        count_next      = count_reg;
        unemit_next     = unemit_reg;
        prev_end_next   = prev_end_reg;
        chunk_cnt_next  = chunk_cnt_reg;
        if (accept)
        begin
            if (text.last_byte)
            begin
                pos_next        = '0;
                inside_next     = 1'b0;
                open_start_next = '0;
                wi_next         = '0;
                count_next      = '0;
                unemit_next     = 1'b0;
                prev_end_next   = '0;
                chunk_cnt_next  = '0;
            end
            else
            begin
                pos_next        = pos_inc;
                inside_next     = !ws;
                open_start_next = (!ws && !inside_reg) ? pos_reg : open_start_reg;
                wi_next         = wi_new;
                count_next      = full ? ov_eff : count_after;
                unemit_next     = unemit_after;
                prev_end_next   = span_end_pos;
                if (emit && (chunk_cnt_reg != CHUNK_MAX))
                begin
                    chunk_cnt_next = chunk_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            inside_reg     <= 1'b0;
            open_start_reg <= '0;
            wi_reg         <= '0;
            count_reg      <= '0;
            unemit_reg     <= 1'b0;
            prev_end_reg   <= '0;
            chunk_cnt_reg  <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            inside_reg     <= inside_next;
            open_start_reg <= open_start_next;
            wi_reg         <= wi_next;
            count_reg      <= count_next;
            unemit_reg     <= unemit_next;
            prev_end_reg   <= prev_end_next;
            chunk_cnt_reg  <= chunk_cnt_next;
        end
    end

endmodule

// File: rtl/wtc_outq.sv
// wtc_outq: result stage waiting on the ring read, then the output register.
// Generates the input stall from the two stages and the output stall.
// Depends on wtc_pkg.
module wtc_outq
    import wtc_pkg::*;
#(
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     text_valid,
    input  logic                     accept,
    input  wtc_pend_t                pend,
    input  logic [POSITION_BITS-1:0] ring_rdata,
    input  logic                     chunk_stall,
    output logic                     text_stall,
    output logic                     chunk_valid,
    output wtc_out_t                 chunk
);

    logic      s1_valid_reg, s1_valid_next;
    wtc_pend_t s1_reg, s1_next;
    logic      o_valid_reg, o_valid_next;
    wtc_out_t  o_reg, o_next;
    logic      s1_move;

    // stage 1 advances whenever the output register is free or draining
    assign s1_move    = s1_valid_reg && (!o_valid_reg || !chunk_stall);
    assign text_stall = text_valid && s1_valid_reg && !s1_move;

    always_comb
    begin
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg && !s1_move;
        if (accept && pend.emit)
        begin
            s1_next       = pend;
            s1_valid_next = 1'b1;
        end

        o_next       = o_reg;
        o_valid_next = o_valid_reg && chunk_stall;
        if (s1_move)
        begin
            o_next.chunk_id    = s1_reg.chunk_id;
            o_next.span_start  = FIELD_W'(ring_rdata);
            o_next.span_end    = s1_reg.span_end;
            o_next.final_chunk = s1_reg.final_chunk;
            o_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        o_reg  <= o_next;
    end

    assign chunk_valid = o_valid_reg;
    assign chunk       = o_reg;

endmodule

// File: rtl/whitespace_token_chunker_unit.sv
// Whitespace token chunker: splits a byte stream into whitespace-separated
// tokens and reports overlapping windows of tokens as byte spans.
// Throughput: one byte per cycle while text_stall is low; each byte costs at most
// one ring write and one ring read, on separate ports of the token start ring.
// A closed chunk is held in the result stage, then in the output register.
// Reset (async, rst_n low): text state and handshake stages clear, max_tokens
// returns to 128, overlap_tokens to 0; the ring is not cleared.
module whitespace_token_chunker_unit
    import wtc_pkg::*;
#(
    parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // byte input channel
    input  logic                  text_valid,
    output logic                  text_stall,
    input  wtc_in_t               text,
    // chunk result channel
    output logic                  chunk_valid,
    input  logic                  chunk_stall,
    output wtc_out_t              chunk,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);

    // Configuration registers. The user must write them only while idle, so the
    // scanner sees them static during a transfer; the block does not enforce it.
    logic [8:0] max_tokens_reg, max_tokens_next;
    logic [7:0] overlap_reg, overlap_next;

    always_comb
    begin
        max_tokens_next = max_tokens_reg;
        overlap_next    = overlap_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_TOKENS:     max_tokens_next = cfg_data[8:0];
                REG_OVERLAP_TOKENS: overlap_next    = cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tokens_reg <= MAX_TOKENS_RESET;
            overlap_reg    <= OVERLAP_TOKENS_RESET;
        end
        else
        begin
            max_tokens_reg <= max_tokens_next;
            overlap_reg    <= overlap_next;
        end
    end

    // A byte transfer completes on valid with no stall.
    logic accept;
    assign accept = text_valid && !text_stall;

    logic                     ring_we;
    logic [IDX_W-1:0]         ring_waddr;
    logic [POSITION_BITS-1:0] ring_wdata;
    logic                     ring_re;
    logic [IDX_W-1:0]         ring_raddr;
    logic [POSITION_BITS-1:0] ring_rdata;
    wtc_pend_t                pend;

    // Scanner: classifies the byte, updates the token/window state and, when
    // a window closes, issues the ring read for the window's first token.
    wtc_scan #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .text           (text),
        .accept         (accept),
        .max_tokens     (max_tokens_reg),
        .overlap_tokens (overlap_reg),
        .ring_we        (ring_we),
        .ring_waddr     (ring_waddr),
        .ring_wdata     (ring_wdata),
        .ring_re        (ring_re),
        .ring_raddr     (ring_raddr),
        .pend           (pend)
    );

    // Start offsets of the most recent tokens; read data is registered and lands in the cycle after the read.
    wtc_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .DATA_W (POSITION_BITS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // Result stage plus output register; the input stalls only when both
    // are occupied and the output side is stalled.
    wtc_outq #(
        .POSITION_BITS (POSITION_BITS)
    ) u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .accept      (accept),
        .pend        (pend),
        .ring_rdata  (ring_rdata),
        .chunk_stall (chunk_stall),
        .text_stall  (text_stall),
        .chunk_valid (chunk_valid),
        .chunk       (chunk)
    );

endmodule

// File: rtl/wtc_checker.sv
// wtc_checker: port-level assertions for the whitespace token chunker.
// Bound to whitespace_token_chunker_unit; depends on wtc_pkg.
module wtc_checker
    import wtc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     text_valid,
    input logic     text_stall,
    input logic     chunk_valid,
    input logic     chunk_stall,
    input wtc_out_t chunk
);

    // a stalled chunk holds
    a_chunk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && chunk_stall |=> chunk_valid && $stable(chunk))
        else $error("chunk changed while stalled");

    // input only backs up when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> chunk_valid && chunk_stall)
        else $error("input stalled without output back-pressure");

    // the chunk after a final one starts a new text
    a_new_text: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && !chunk_stall && chunk.final_chunk |=>
            !chunk_valid || (chunk.chunk_id == '0))
        else $error("chunk id did not restart after final chunk");

    // back-to-back chunks count up by one, saturate, or restart
    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && !chunk_stall && !chunk.final_chunk ##1 chunk_valid |->
            (chunk.chunk_id == '0) ||
            ({1'b0, chunk.chunk_id} == {1'b0, $past(chunk.chunk_id)} + 32'd1) ||
            (($past(chunk.chunk_id) == {FIELD_W{1'b1}}) &&
             (chunk.chunk_id == {FIELD_W{1'b1}})))
        else $error("chunk id sequence broken");

endmodule

bind whitespace_token_chunker_unit wtc_checker u_wtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .chunk       (chunk)
);
